/* rtl/manchester_pulse_frame_receiver_core_assert.svh */
// Assertion macros for the Manchester pulse frame receiver.
// Used by the top level; needs no other file.
`ifndef MANCHESTER_PULSE_FRAME_RECEIVER_CORE_ASSERT_SVH
`define MANCHESTER_PULSE_FRAME_RECEIVER_CORE_ASSERT_SVH

// a holds at an edge -> b holds at the same edge
`define MPFR_ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("mpfr: implication check failed");

// a holds at an edge -> b holds at the next edge
`define MPFR_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("mpfr: next-cycle check failed");

`endif

/* rtl/mpfr_pkg.sv */
// Shared types and constants for the Manchester pulse frame receiver.
// No dependencies.
package mpfr_pkg;

  localparam int FRAME_BITS = 8;

  localparam logic [15:0] NO_WIDTH = 16'hFAFA;

  localparam logic [1:0] CMD_ARM     = 2'd0;
  localparam logic [1:0] CMD_EDGE    = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  localparam logic [1:0] ST_NAK   = 2'd0;
  localparam logic [1:0] ST_VALUE = 2'd1;
  localparam logic [1:0] ST_COLL  = 2'd2;

  localparam logic [1:0] CFG_HALF_MIN   = 2'd0;
  localparam logic [1:0] CFG_HALF_LIMIT = 2'd1;
  localparam logic [1:0] CFG_FULL_MIN   = 2'd2;
  localparam logic [1:0] CFG_FULL_LIMIT = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT_START,
    PH_AFTER_START,
    PH_AFTER_HALF,
    PH_AFTER_BOUNDARY,
    PH_INVALID
  } phase_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] pulse_width;
    logic        line_idle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  data_byte;
    logic [3:0]  bits_seen;
    logic [15:0] bad_width;
  } out_item_t;

  typedef struct packed {
    logic [15:0] half_min;
    logic [15:0] half_limit;
    logic [15:0] full_min;
    logic [15:0] full_limit;
  } cfg_t;

endpackage

/* rtl/mpfr_cfg_regs.sv */
// Pulse window registers of the Manchester pulse frame receiver.
// Depends on mpfr_pkg.
module mpfr_cfg_regs import mpfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HALF_MIN:   cfg_d.half_min   = cfg_wdata_i;
        CFG_HALF_LIMIT: cfg_d.half_limit = cfg_wdata_i;
        CFG_FULL_MIN:   cfg_d.full_min   = cfg_wdata_i;
        CFG_FULL_LIMIT: cfg_d.full_limit = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_min   <= 16'd316;
      cfg_q.half_limit <= 16'd516;
      cfg_q.full_min   <= 16'd733;
      cfg_q.full_limit <= 16'd933;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/mpfr_decoder.sv */
// Frame state machine: pulse classification, bit decoding, result build.
// Depends on mpfr_pkg.
module mpfr_decoder import mpfr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      accept_i,
  input  in_item_t  item_i,
  output logic      res_valid_o,
  output out_item_t res_o,
  output phase_e    phase_o
);

  phase_e      phase_q, phase_d;
  logic        prev_bit_q, prev_bit_d;
  logic [3:0]  bit_cnt_q, bit_cnt_d;
  logic [7:0]  shift_q, shift_d;
  logic [1:0]  status_q, status_d;
  logic [15:0] width_q, width_d;

  logic        is_half, is_full, frame_done;
  logic [3:0]  bit_cnt_inc;
  logic [1:0]  final_status;

  assign is_half = (item_i.pulse_width >= cfg_i.half_min) &&
                   (item_i.pulse_width <  cfg_i.half_limit);
  assign is_full = (item_i.pulse_width >= cfg_i.full_min) &&
                   (item_i.pulse_width <  cfg_i.full_limit);

  // count saturates at fifteen
  assign bit_cnt_inc = (bit_cnt_q == 4'hF) ? bit_cnt_q : bit_cnt_q + 4'd1;

  // counts above fifteen can never be matched by the saturated counter
  assign frame_done = (FRAME_BITS <= 15) && (bit_cnt_q == 4'(FRAME_BITS));

  always_comb begin
    if (phase_q == PH_WAIT_START) begin
      final_status = ST_NAK;
    end else if (!item_i.line_idle || !frame_done) begin
      final_status = ST_COLL;
    end else begin
      final_status = status_q;
    end
  end

  // next state
  always_comb begin
    phase_d    = phase_q;
    prev_bit_d = prev_bit_q;
    bit_cnt_d  = bit_cnt_q;
    shift_d    = shift_q;
    status_d   = status_q;
    width_d    = width_q;
    if (accept_i) begin
      case (item_i.command)
        CMD_ARM: begin
          shift_d   = 8'd0;
          bit_cnt_d = 4'd0;
          status_d  = ST_NAK;
          width_d   = NO_WIDTH;
          phase_d   = PH_WAIT_START;
        end
        CMD_EDGE: begin
          case (phase_q)
            PH_WAIT_START: begin
              status_d = ST_VALUE;
              width_d  = item_i.pulse_width;
              phase_d  = PH_AFTER_START;
            end
            PH_AFTER_START: begin
              if (is_half) begin
                prev_bit_d = 1'b1;
                phase_d    = PH_AFTER_HALF;
              end else begin
                width_d  = item_i.pulse_width;
                status_d = ST_COLL;
                phase_d  = PH_INVALID;
              end
            end
            PH_AFTER_HALF: begin
              if (is_half) begin
                phase_d = PH_AFTER_BOUNDARY;
              end else if (is_full) begin
                // full pulse: bit flips, then is shifted in
                prev_bit_d = ~prev_bit_q;
                shift_d    = {shift_q[6:0], ~prev_bit_q};
                bit_cnt_d  = bit_cnt_inc;
              end else begin
                width_d  = item_i.pulse_width;
                status_d = ST_COLL;
                phase_d  = PH_INVALID;
              end
            end
            PH_AFTER_BOUNDARY: begin
              if (is_half) begin
                shift_d   = {shift_q[6:0], prev_bit_q};
                bit_cnt_d = bit_cnt_inc;
                phase_d   = PH_AFTER_HALF;
              end else begin
                width_d  = item_i.pulse_width;
                status_d = ST_COLL;
                phase_d  = PH_INVALID;
              end
            end
            default: ;
          endcase
        end
        CMD_TIMEOUT: begin
          if (phase_q != PH_IDLE) begin
            status_d = final_status;
            phase_d  = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // outputs
  always_comb begin
    res_valid_o     = accept_i && (item_i.command == CMD_TIMEOUT) && (phase_q != PH_IDLE);
    res_o.status    = final_status;
    res_o.data_byte = shift_q;
    res_o.bits_seen = bit_cnt_q;
    res_o.bad_width = width_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      prev_bit_q <= 1'b1;
      bit_cnt_q  <= 4'd0;
      shift_q    <= 8'd0;
      status_q   <= ST_NAK;
      width_q    <= NO_WIDTH;
    end else begin
      phase_q    <= phase_d;
      prev_bit_q <= prev_bit_d;
      bit_cnt_q  <= bit_cnt_d;
      shift_q    <= shift_d;
      status_q   <= status_d;
      width_q    <= width_d;
    end
  end

  assign phase_o = phase_q;

endmodule

/* rtl/mpfr_out_fifo.sv */
// Two-entry result buffer between the decoder and the output channel.
// Depends on mpfr_pkg.
module mpfr_out_fifo import mpfr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t push_item_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  out_item_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign pop         = out_valid_o && out_ready_i;
  assign out_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* rtl/manchester_pulse_frame_receiver_core.sv */
// Channel    Signals                                Payload
// input      in_valid_i / in_ready_o                in_item_i (command, width, idle)
// output     out_valid_o / out_ready_i              out_item_o (status, byte, bits, width)
// config     cfg_we_i, cfg_idx_i, cfg_wdata_i       16-bit window registers
//
// One item per cycle while in_ready_o is high: window compares and the shift
// happen in the cycle of acceptance, a timeout's result enters a two-entry
// output buffer, where it is registered when its timeout item is accepted.
// in_ready_o drops only while both buffer entries hold untaken results.
// Reset is asynchronous, active low; no clearing pass is needed.
// Top level of the Manchester pulse frame receiver; depends on mpfr_pkg,
// mpfr_cfg_regs, mpfr_decoder, mpfr_out_fifo and the assertion header.
`include "manchester_pulse_frame_receiver_core_assert.svh"

module manchester_pulse_frame_receiver_core import mpfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  cfg_t      cfg;
  logic      accept;
  logic      res_valid;
  out_item_t res;
  logic      fifo_full;
  phase_e    phase;

  assign in_ready_o = ~fifo_full;
  assign accept     = in_valid_i && in_ready_o;

  mpfr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mpfr_decoder u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .phase_o     (phase)
  );

  mpfr_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_item_i (res),
    .full_o      (fifo_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  `MPFR_ASSERT_IMPL(a_res_only_on_timeout, clk_i, rst_ni, res_valid,
                    accept && (in_item_i.command == CMD_TIMEOUT))
  `MPFR_ASSERT_NEXT(a_arm_waits_start, clk_i, rst_ni,
                    accept && (in_item_i.command == CMD_ARM), phase == PH_WAIT_START)
  `MPFR_ASSERT_IMPL(a_value_needs_full_frame, clk_i, rst_ni,
                    res_valid && (res.status == ST_VALUE),
                    (res.bits_seen == 4'(FRAME_BITS)) && in_item_i.line_idle)

endmodule
